// ===== design/lrp_pkg.sv =====
`default_nettype none

package lrp_pkg;

   // Widest register supported; every word on the ports has this many bits.
   localparam int MAX_WIDTH = 20;
   localparam int MIN_WIDTH = 3;
   localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);

   typedef logic [MAX_WIDTH-1:0]  word_type;
   typedef logic [WIDTH_BITS-1:0] width_type;

   localparam word_type LIMIT_MAX = '1;
   localparam word_type SEED      = word_type'(1);

   // Register geometry derived from the range limit.
   typedef struct packed {
      word_type mask;   // bits that belong to the register
      word_type top;    // one-hot position where the feedback enters
      word_type taps;   // bits that feed the parity
   } geom_type;

   // Maximal-length tap sets for widths 3 to 20.
   function automatic word_type tap_set(input width_type n);
      word_type taps;
      unique case (n)
         width_type'(3):  taps = word_type'(20'h00003);
         width_type'(4):  taps = word_type'(20'h00003);
         width_type'(5):  taps = word_type'(20'h00005);
         width_type'(6):  taps = word_type'(20'h00003);
         width_type'(7):  taps = word_type'(20'h00003);
         width_type'(8):  taps = word_type'(20'h0001D);
         width_type'(9):  taps = word_type'(20'h00011);
         width_type'(10): taps = word_type'(20'h00009);
         width_type'(11): taps = word_type'(20'h00005);
         width_type'(12): taps = word_type'(20'h00941);
         width_type'(13): taps = word_type'(20'h01601);
         width_type'(14): taps = word_type'(20'h02A01);
         width_type'(15): taps = word_type'(20'h00003);
         width_type'(16): taps = word_type'(20'h0100B);
         width_type'(17): taps = word_type'(20'h00009);
         width_type'(18): taps = word_type'(20'h00081);
         width_type'(19): taps = word_type'(20'h62001);
         width_type'(20): taps = word_type'(20'h00009);
         default:         taps = '0;
      endcase
      return taps;
   endfunction

   // The width is the smallest n of at least three with 2^n above the limit.
   function automatic geom_type geom_for_limit(input word_type limit);
      width_type n;
      geom_type  g;
      n = width_type'(MIN_WIDTH);
      for (int i = MIN_WIDTH; i < MAX_WIDTH; i++) begin
         if (limit[i]) begin
            n = width_type'(i + 1);
         end
      end
      for (int i = 0; i < MAX_WIDTH; i++) begin
         g.mask[i] = (width_type'(i) < n);
         g.top[i]  = (width_type'(i + 1) == n);
      end
      g.taps = tap_set(n);
      return g;
   endfunction

   localparam geom_type GEOM_RESET = geom_for_limit(LIMIT_MAX);

endpackage

`default_nettype wire

// ===== design/lrp_step.sv =====
`default_nettype none

module lrp_step (
   input  wire lrp_pkg::word_type  cur_value,
   input  wire                     restart,
   input  wire lrp_pkg::geom_type  geom,
   input  wire lrp_pkg::word_type  range_limit,
   output lrp_pkg::word_type       next_value,
   output logic                    in_range,
   output logic                    sequence_end
);

   lrp_pkg::word_type seeded;
   logic              feedback;

   always_comb begin
      seeded = restart ? lrp_pkg::SEED : (cur_value & geom.mask);
      feedback = ^(seeded & geom.taps);
      next_value = (seeded >> 1) | (feedback ? geom.top : '0);
      in_range = (next_value <= range_limit);
      sequence_end = (next_value == lrp_pkg::SEED);
   end

endmodule

`default_nettype wire

// ===== design/lrp_core_regs.sv =====
`default_nettype none

module lrp_core_regs (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire lrp_pkg::word_type  csr_wr_data,
   input  wire                     step_en,
   input  wire lrp_pkg::word_type  step_value,
   output lrp_pkg::word_type       cur_value,
   output lrp_pkg::geom_type       geom,
   output lrp_pkg::word_type       range_limit
);

   lrp_pkg::word_type shift_reg_ff, shift_reg_in;
   lrp_pkg::word_type limit_ff, limit_in;
   lrp_pkg::geom_type geom_ff, geom_in;

   // A limit write reseeds the register; the geometry is worked out once here.
   always_comb begin
      shift_reg_in = shift_reg_ff;
      limit_in = limit_ff;
      geom_in = geom_ff;
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
         geom_in = lrp_pkg::geom_for_limit(csr_wr_data);
         shift_reg_in = lrp_pkg::SEED;
      end else if (step_en) begin
         shift_reg_in = step_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_reg_ff <= lrp_pkg::SEED;
         limit_ff <= lrp_pkg::LIMIT_MAX;
         geom_ff <= lrp_pkg::GEOM_RESET;
      end else begin
         shift_reg_ff <= shift_reg_in;
         limit_ff <= limit_in;
         geom_ff <= geom_in;
      end
   end

   assign cur_value = shift_reg_ff;
   assign geom = geom_ff;
   assign range_limit = limit_ff;

endmodule

`default_nettype wire

// ===== design/lrp_core.sv =====
// Range permutation generator: every value from 1 to the range limit appears
// exactly once, flagged in range, over one full cycle of a Fibonacci LFSR.
// Input channel (req_valid, req_stall, req_restart): each accepted word steps
// the register once; req_restart reseeds it to 1 before the step.
// Result channel (rsp_valid, rsp_stall, rsp_value, rsp_in_range,
// rsp_sequence_end): one word per input word, in order.
// Configuration: csr_wr_en with csr_wr_data writes the range limit, which sets
// the register width and taps and reseeds the register to 1. Write it only
// when no result is outstanding.
// The result is registered: rsp_valid rises in the cycle after acceptance.
// One word per cycle when not stalled, set by one shift and tap parity step.
// Reset (synchronous) sets the limit to 2^20-1, seeds the register to 1 and
// empties the result register. While rsp_stall holds a pending result, the
// result stays unchanged and req_stall is raised; a new word is taken in the
// same cycle the pending result leaves.
`default_nettype none

module lfsr_range_permutation_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire lrp_pkg::word_type  csr_wr_data,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     req_restart,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output lrp_pkg::word_type       rsp_value,
   output logic                    rsp_in_range,
   output logic                    rsp_sequence_end
);

   lrp_pkg::word_type cur_value;
   lrp_pkg::geom_type geom;
   lrp_pkg::word_type range_limit;
   lrp_pkg::word_type next_value;
   logic              next_in_range;
   logic              next_end;
   logic              accept;

   logic              rsp_valid_ff, rsp_valid_in;
   lrp_pkg::word_type rsp_value_ff;
   logic              rsp_in_range_ff;
   logic              rsp_end_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;

   lrp_core_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (accept),
      .step_value  (next_value),
      .cur_value   (cur_value),
      .geom        (geom),
      .range_limit (range_limit)
   );

   lrp_step u_step (
      .cur_value    (cur_value),
      .restart      (req_restart),
      .geom         (geom),
      .range_limit  (range_limit),
      .next_value   (next_value),
      .in_range     (next_in_range),
      .sequence_end (next_end)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff <= next_value;
         rsp_in_range_ff <= next_in_range;
         rsp_end_ff <= next_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_in_range = rsp_in_range_ff;
   assign rsp_sequence_end = rsp_end_ff;

endmodule

`default_nettype wire
